FILE: hw/rtl/crc32_wide_lookup_core_defines.svh
// assertion macros for the crc32 wide lookup core
// both sample on clk and are disabled while rst_n is low
`ifndef CRC32_WIDE_LOOKUP_CORE_DEFINES_SVH
`define CRC32_WIDE_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication
`define CWL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CWL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cwl_pkg.sv
`default_nettype none

package cwl_pkg;

  localparam int unsigned CRC_W          = 32;
  localparam logic [31:0] CRC_POLY       = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_MSB        = 32'h8000_0000;
  localparam int unsigned MAX_LANE_BYTES = 32;
  localparam int unsigned MAX_LANE_BITS  = MAX_LANE_BYTES * 8;
  localparam int unsigned LANE_BYTES_DEF = 32;
  localparam int unsigned STATE_DEPTH    = 1;

  // row i holds the input bits that feed crc bit i
  typedef logic [CRC_W-1:0][CRC_W-1:0]         shift_mat_t;
  typedef logic [CRC_W-1:0][MAX_LANE_BITS-1:0] data_mat_t;

  // advance the register by a number of zero-bit steps (elaboration only)
  function automatic logic [31:0] crc_adv(input logic [31:0] r, input int unsigned steps);
    logic [31:0] v;
    v = r;
    for (int unsigned s = 0; s < steps; s++) begin
      v = v[31] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

  // map of the running register through nbytes message bytes
  function automatic shift_mat_t crc_shift_mat(input int unsigned nbytes);
    shift_mat_t  m;
    logic [31:0] col;
    m = '0;
    for (int unsigned j = 0; j < CRC_W; j++) begin
      col = crc_adv(32'h1 << j, 8 * nbytes);
      for (int unsigned i = 0; i < CRC_W; i++) begin
        m[i][j] = col[i];
      end
    end
    return m;
  endfunction

  // contribution of each bit of a right-aligned word, register starting at zero
  // byte k is followed by lanes-1-k bytes; its bit b lands reversed at bit 31-b
  function automatic data_mat_t crc_data_mat(input int unsigned lanes);
    data_mat_t   m;
    logic [31:0] col;
    m = '0;
    for (int unsigned k = 0; k < lanes * 8; k++) begin
      col = crc_adv(CRC_MSB >> (k % 8), 8 * (lanes - k / 8));
      for (int unsigned i = 0; i < CRC_W; i++) begin
        m[i][k] = col[i];
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cwl_ram.sv
`default_nettype none

// generic single-port-write, single-port-read ram, registered read
module cwl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/crc32_wide_lookup_core.sv
`default_nettype none

// channel  dir  handshake            payload
// in       in   in_valid / in_stall  in_bytes_0_to_7 .. in_bytes_24_to_31, in_valid_count,
//                                    in_start_flag, in_end_flag
// out      out  out_valid / out_stall out_crc_result
//
// one item per cycle while in_stall is low; out_valid rises as the end item leaves stage 1,
// set by the read-modify-write of the running crc in the state ram
// (registered ram read, write-to-read forwarding covers back-to-back items)
// rst_n is synchronous; after reset the running crc reads as all ones
// in_stall rises only when an end item waits for a full, stalled output register

`include "crc32_wide_lookup_core_defines.svh"

module crc32_wide_lookup_core #(
  parameter int unsigned LANE_BYTES = cwl_pkg::LANE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_bytes_0_to_7,
  input  wire logic [63:0] in_bytes_8_to_15,
  input  wire logic [63:0] in_bytes_16_to_23,
  input  wire logic [63:0] in_bytes_24_to_31,
  input  wire logic [5:0]  in_valid_count,
  input  wire logic        in_start_flag,
  input  wire logic        in_end_flag,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_crc_result
);

  localparam int unsigned LB_BITS = LANE_BYTES * 8;
  localparam int unsigned CNT_W   = $clog2(LANE_BYTES + 1);
  localparam int unsigned ST_AW   = (cwl_pkg::STATE_DEPTH > 1) ?
                                    $clog2(cwl_pkg::STATE_DEPTH) : 1;

  // contribution matrix of a right-aligned word, built at elaboration
  localparam cwl_pkg::data_mat_t DMAT = cwl_pkg::crc_data_mat(LANE_BYTES);

  // ---------------------------------------------------------------------------
  // front end: saturate the count, right-align the valid bytes, fold the lanes
  // ---------------------------------------------------------------------------
  logic                              acc;
  logic [cwl_pkg::MAX_LANE_BITS-1:0] in_all;
  logic [LB_BITS-1:0]                win;
  logic [LB_BITS-1:0]                algn;
  logic [CNT_W-1:0]                  cnt_sat;
  logic [CNT_W-1:0]                  pad;
  logic [31:0]                       g_nxt;

  assign acc    = in_valid & ~in_stall;
  assign in_all = {in_bytes_24_to_31, in_bytes_16_to_23, in_bytes_8_to_15, in_bytes_0_to_7};
  assign win    = in_all[LB_BITS-1:0];

  // counts past the lane width saturate; bytes at or beyond the width are ignored
  assign cnt_sat = (in_valid_count > 6'(LANE_BYTES)) ? CNT_W'(LANE_BYTES)
                                                     : CNT_W'(in_valid_count);
  assign pad     = CNT_W'(LANE_BYTES) - cnt_sat;

  // leading zero bytes leave a zero register unchanged, so the valid bytes are
  // pushed to the top of the window; bytes past the count fall off the end
  assign algn = win << {pad, 3'b000};

  // each crc bit is the parity of the aligned bits that reach it
  always_comb begin
    for (int unsigned i = 0; i < cwl_pkg::CRC_W; i++) begin
      g_nxt[i] = ^(DMAT[i][LB_BITS-1:0] & algn);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: the data part waits here while the running crc is read from ram
  // ---------------------------------------------------------------------------
  logic             s1_valid_r;
  logic [31:0]      s1_g_r;
  logic [CNT_W-1:0] s1_n_r;
  logic             s1_start_r;
  logic             s1_end_r;
  logic             s1_fire;

  // forwarding and ram-valid bookkeeping
  logic             st_vld_r;    // ram entry written since reset
  logic             rd_ok_r;     // ram data of this read is meaningful
  logic             fwd_r;       // write to the entry hit the same edge as the read
  logic [31:0]      fwd_data_r;  // last value written back

  logic [31:0]      ram_rdata;
  logic [ST_AW-1:0] st_addr;
  logic [31:0]      r_eff;
  logic [31:0]      fprod [LANE_BYTES+1];
  logic [31:0]      crc_nxt;
  logic [31:0]      wb_nxt;

  logic             out_valid_r;
  logic [31:0]      out_crc_r;

  // an end item needs a free output register; other items always move on
  assign s1_fire  = s1_valid_r & (~s1_end_r | ~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_fire;

  assign st_addr = '0;

  cwl_ram #(
    .WIDTH (cwl_pkg::CRC_W),
    .DEPTH (cwl_pkg::STATE_DEPTH)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (st_addr),
    .wr_data (wb_nxt),
    .rd_en   (acc),
    .rd_addr (st_addr),
    .rd_data (ram_rdata)
  );

  // running crc seen by the item in stage 1
  always_comb begin
    if (s1_start_r) begin
      r_eff = cwl_pkg::CRC_INIT;
    end else if (fwd_r) begin
      r_eff = fwd_data_r;
    end else if (rd_ok_r) begin
      r_eff = ram_rdata;
    end else begin
      r_eff = cwl_pkg::CRC_INIT;
    end
  end

  // running crc pushed through n message bytes, one product per possible count
  for (genvar n = 0; n <= LANE_BYTES; n++) begin : g_shift
    localparam cwl_pkg::shift_mat_t SMAT = cwl_pkg::crc_shift_mat(n);
    logic [31:0] prod;
    always_comb begin
      for (int unsigned i = 0; i < cwl_pkg::CRC_W; i++) begin
        prod[i] = ^(SMAT[i] & r_eff);
      end
    end
    assign fprod[n] = prod;
  end

  assign crc_nxt = fprod[s1_n_r] ^ s1_g_r;
  // end of message puts the register back to all ones for the next message
  assign wb_nxt  = s1_end_r ? cwl_pkg::CRC_INIT : crc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_vld_r    <= 1'b0;
      rd_ok_r     <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
        rd_ok_r    <= st_vld_r;
        fwd_r      <= s1_fire;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        st_vld_r <= 1'b1;
      end
      if (s1_fire && s1_end_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_g_r     <= g_nxt;
      s1_n_r     <= cnt_sat;
      s1_start_r <= in_start_flag;
      s1_end_r   <= in_end_flag;
    end
    if (s1_fire) begin
      fwd_data_r <= wb_nxt;
    end
    if (s1_fire && s1_end_r) begin
      out_crc_r <= crc_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_crc_result = out_crc_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `CWL_ASSERT_NXT(a_end_restarts, s1_fire && s1_end_r, fwd_data_r == cwl_pkg::CRC_INIT, "running crc not restored after end item")
  `CWL_ASSERT_IMP(a_result_source, $rose(out_valid_r), $past(s1_fire && s1_end_r), "result appeared without an end item")
  `CWL_ASSERT_NXT(a_s1_holds, s1_valid_r && !s1_fire, s1_valid_r && $stable(s1_g_r) && $stable(s1_n_r), "stalled stage 1 item changed")

endmodule

`default_nettype wire

FILE: tb/crc32_wide_lookup_core_tb.sv
`default_nettype none

module crc32_wide_lookup_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIR       = 22;
  localparam int N_RANDOM    = 750;
  localparam int HOLD_CYCLES = 400;     // long output hold-off
  localparam int TAIL_CYCLES = 20;      // idle time after the last result
  localparam int DRAIN_LIMIT = 5000;
  localparam int CYCLE_LIMIT = 200_000;

  // lane patterns for the directed table
  localparam logic [63:0] ALL0 = 64'h0000_0000_0000_0000;
  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALTA = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] ALT5 = 64'h5555_5555_5555_5555;
  localparam logic [63:0] RAMP = 64'h0123_4567_89AB_CDEF;

  // one 32-byte word of a message; pinned rows carry a crc known by inspection
  typedef struct {
    logic [63:0] lane0;
    logic [63:0] lane1;
    logic [63:0] lane2;
    logic [63:0] lane3;
    logic [5:0]  count;
    logic        first;
    logic        last;
    bit          pinned;
    logic [31:0] pinned_crc;
  } crc_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_bytes_0_to_7 = '0;
  logic [63:0] in_bytes_8_to_15 = '0;
  logic [63:0] in_bytes_16_to_23 = '0;
  logic [63:0] in_bytes_24_to_31 = '0;
  logic [5:0]  in_valid_count = '0;
  logic        in_start_flag = 1'b0;
  logic        in_end_flag = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_crc_result;

  logic [31:0] crc_state = cwl_pkg::CRC_INIT;   // predicted running crc
  logic [31:0] crc_expect[$];          // crcs still owed by the block
  int          items_taken = 0;
  int          errors = 0;
  int          cycles = 0;

  // directed words: extremes, zero and oversize counts, short words mid-message,
  // restart without start flag after an end, restart with start flag mid-message
  crc_word_t dir_table [N_DIR] = '{
    // empty message straight after reset: register still all ones
    '{ALL1, ALL1, ALL1, ALL1, 6'd0,  1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // zero count with start: nothing absorbed
    '{ALTA, ALTA, ALTA, ALTA, 6'd0,  1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ALL0, ALL0, ALL0, ALL0, 6'd32, 1'b1, 1'b1, 1'b0, 32'h0},
    '{ALL1, ALL1, ALL1, ALL1, 6'd32, 1'b1, 1'b1, 1'b0, 32'h0},
    '{ALL1, ALL0, ALL0, ALL0, 6'd1,  1'b1, 1'b1, 1'b0, 32'h0},
    '{ALL0, ALL1, ALL1, ALL1, 6'd1,  1'b1, 1'b1, 1'b0, 32'h0},
    // counts past the lane width saturate
    '{ALL1, ALL1, ALL1, ALL1, 6'd33, 1'b1, 1'b1, 1'b0, 32'h0},
    '{RAMP, ALTA, ALT5, ALL1, 6'd63, 1'b1, 1'b1, 1'b0, 32'h0},
    // short word at the start of a message
    '{RAMP, ALT5, ALTA, RAMP, 6'd5,  1'b1, 1'b0, 1'b0, 32'h0},
    '{ALTA, ALL1, RAMP, ALL0, 6'd32, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ALT5, RAMP, ALL1, ALTA, 6'd17, 1'b0, 1'b1, 1'b0, 32'h0},
    // no start flag after an end: fresh message anyway
    '{RAMP, RAMP, RAMP, RAMP, 6'd8,  1'b0, 1'b1, 1'b0, 32'h0},
    // start flag mid-message throws away the partial crc
    '{ALL1, ALL1, ALL1, ALL1, 6'd32, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ALTA, ALT5, ALTA, ALT5, 6'd32, 1'b1, 1'b1, 1'b0, 32'h0},
    // zero count mid-message leaves the register alone
    '{RAMP, ALTA, RAMP, ALT5, 6'd32, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ALL0, ALL0, ALL0, ALL0, 6'd0,  1'b0, 1'b0, 1'b0, 32'h0},
    '{ALL1, ALL1, ALL1, ALL1, 6'd31, 1'b0, 1'b1, 1'b0, 32'h0},
    '{ALL0, ALL0, ALL0, ALL0, 6'd0,  1'b1, 1'b0, 1'b0, 32'h0},
    '{ALL1, ALL1, ALL1, ALL1, 6'd0,  1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ALT5, ALL0, ALL1, RAMP, 6'd2,  1'b0, 1'b0, 1'b0, 32'h0},
    '{ALTA, RAMP, ALL0, ALL1, 6'd32, 1'b0, 1'b1, 1'b0, 32'h0},
    '{ALL0, ALL0, ALL0, ALL1, 6'd24, 1'b1, 1'b1, 1'b0, 32'h0}
  };

  crc32_wide_lookup_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_bytes_0_to_7   (in_bytes_0_to_7),
    .in_bytes_8_to_15  (in_bytes_8_to_15),
    .in_bytes_16_to_23 (in_bytes_16_to_23),
    .in_bytes_24_to_31 (in_bytes_24_to_31),
    .in_valid_count    (in_valid_count),
    .in_start_flag     (in_start_flag),
    .in_end_flag       (in_end_flag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_crc_result    (out_crc_result)
  );

  always #5ns clk = ~clk;

  task automatic flag_error(input string msg);
    $display("error at %0t: %s", $time, msg);
    errors++;
  endtask

  // one message byte into the register: bit-reversed into the top byte,
  // then eight msb-first shifts against the polynomial
  function automatic logic [31:0] crc_absorb_byte(input logic [31:0] r, input logic [7:0] d);
    logic [7:0] rev;
    for (int b = 0; b < 8; b++) rev[b] = d[7-b];
    r = r ^ {rev, 24'h0};
    for (int k = 0; k < 8; k++) r = r[31] ? ((r << 1) ^ cwl_pkg::CRC_POLY) : (r << 1);
    return r;
  endfunction

  // fold one accepted word into the predicted crc, owe a result on end of message
  task automatic crc_fold_word(input crc_word_t w);
    logic [255:0] bytes;
    logic [31:0]  r;
    int           n;
    bytes = {w.lane3, w.lane2, w.lane1, w.lane0};
    n = (w.count > cwl_pkg::LANE_BYTES_DEF) ? cwl_pkg::LANE_BYTES_DEF : int'(w.count);
    r = w.first ? cwl_pkg::CRC_INIT : crc_state;
    for (int i = 0; i < n; i++) r = crc_absorb_byte(r, bytes[i*8 +: 8]);
    if (w.last) begin
      crc_expect.push_back(w.pinned ? w.pinned_crc : r);
      crc_state = cwl_pkg::CRC_INIT;
    end else begin
      crc_state = r;
    end
  endtask

  // hold the word on the input until the block takes it
  task automatic offer_word(input crc_word_t w);
    in_valid          <= 1'b1;
    in_bytes_0_to_7   <= w.lane0;
    in_bytes_8_to_15  <= w.lane1;
    in_bytes_16_to_23 <= w.lane2;
    in_bytes_24_to_31 <= w.lane3;
    in_valid_count    <= w.count;
    in_start_flag     <= w.first;
    in_end_flag       <= w.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_taken++;
    crc_fold_word(w);
  endtask

  // stop offering until every owed crc has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (crc_expect.size() != 0);
  endtask

  function automatic logic [63:0] rand_lane();
    case ($urandom_range(0, 15))
      0:       return ALL0;
      1:       return ALL1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result checker: every taken result against the oldest owed crc
  always @(posedge clk) begin : result_check
    logic [31:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (crc_expect.size() == 0) begin
        flag_error($sformatf("crc %08h with no message ended", out_crc_result));
      end else begin
        want = crc_expect.pop_front();
        if (out_crc_result !== want)
          flag_error($sformatf("crc_result %08h, expected %08h", out_crc_result, want));
      end
    end
  end

  // receiver: stall pattern that changes mode now and then, plus one long hold-off
  // once the random part is under way so the output fills and in_stall rises
  initial begin : receiver
    int  mode_left;
    int  stall_pct;
    bit  held;
    mode_left = 0;
    stall_pct = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_taken >= N_DIR + 120) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // sender
  initial begin : stimulus
    crc_word_t w;
    int        burst_left;
    int        nwords;
    int        g;
    bit        paused;
    burst_left = 0;
    paused     = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, back to back with the odd gap
    for (int i = 0; i < N_DIR; i++) begin
      offer_word(dir_table[i]);
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    wait_for_results();

    // random messages: mostly well formed, some noise counts and stray flags
    while (items_taken < N_DIR + N_RANDOM) begin
      if (!paused && items_taken >= N_DIR + 450) begin
        wait_for_results();
        paused = 1'b1;
      end
      nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int k = 0; k < nwords; k++) begin
        // bursts with random gaps, some bursts long enough to run gap-free
        if (burst_left == 0) begin
          g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
          end
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        w.lane0      = rand_lane();
        w.lane1      = rand_lane();
        w.lane2      = rand_lane();
        w.lane3      = rand_lane();
        w.first      = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
        w.last       = (k == nwords - 1);
        w.pinned     = 1'b0;
        w.pinned_crc = '0;
        if ($urandom_range(0, 9) == 0)
          w.count = 6'($urandom_range(0, 63));
        else if (w.last)
          w.count = 6'($urandom_range(1, 32));
        else
          w.count = 6'd32;
        offer_word(w);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow the pipeline to settle
    g = 0;
    while (crc_expect.size() != 0 && g < DRAIN_LIMIT) begin
      @(posedge clk);
      g++;
    end
    if (crc_expect.size() != 0)
      flag_error($sformatf("%0d crcs never came out", crc_expect.size()));
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
